@@ design/lcdnw_pkg.sv @@
// shared widths, register indexes, defaults and helpers for the lcd nibble write mapper
// no dependencies; imported by every other design file except lcdnw_ram
package lcdnw_pkg;

  localparam int ADDR_W     = 20;
  localparam int PITCH_W    = 12;
  localparam int LINE_W     = 6;
  localparam int NIB_W      = 4;
  localparam int COL_OUT_W  = 6;
  localparam int ROW_OUT_W  = 6;
  localparam int SHADOW_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // radix-4 divider: two quotient bits per cycle
  localparam int DIV_STEPS  = ADDR_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int ROW_NIBBLES_DEF = 34;
  localparam int SHADOW_COLS_DEF = 36;
  localparam int SCREEN_ROWS_DEF = 64;
  localparam int FRAME_WIDTH_DEF = 262;

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_LINE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MENU_START    = 2'd3;

  localparam logic [ADDR_W-1:0]   DISPLAY_START_RST = '0;
  localparam logic [PITCH_W-1:0]  LINE_PITCH_RST    = 12'd34;
  localparam logic [LINE_W-1:0]   LAST_LINE_RST     = 6'd63;
  localparam logic [ADDR_W-1:0]   MENU_START_RST    = '0;

  // shadow entry value for a nibble never written
  localparam logic [SHADOW_W-1:0] SHADOW_UNKNOWN = 5'h10;

  typedef struct packed {
    logic [ADDR_W-1:0]  quo;
    logic [PITCH_W-1:0] rem;
  } div_res_t;

  // pixel i covers display column col*8 + 2*i + 1
  function automatic logic [NIB_W-1:0] vis_mask(input int col, input int frame_w);
    logic [NIB_W-1:0] m;
    m = '0;
    for (int i = 0; i < NIB_W; i++) begin
      if (col * 8 + i * 2 + 1 < frame_w) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

@@ design/lcdnw_if.sv @@
// valid/ready channel interfaces for write words in and changed-nibble words out
// depends on lcdnw_pkg
interface lcdnw_in_if import lcdnw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ADDR_W-1:0] address;
  logic [NIB_W-1:0]  nibble;

  modport source(output valid, cmd, address, nibble, input ready);
  modport sink(input valid, cmd, address, nibble, output ready);
endinterface

interface lcdnw_out_if import lcdnw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COL_OUT_W-1:0] column;
  logic [ROW_OUT_W-1:0] row;
  logic [NIB_W-1:0]     pattern;
  logic [NIB_W-1:0]     visible_mask;
  logic                 last;

  modport source(output valid, column, row, pattern, visible_mask, last, input ready);
  modport sink(input valid, column, row, pattern, visible_mask, last, output ready);
endinterface

@@ design/lcdnw_ram.sv @@
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module lcdnw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/lcdnw_div.sv @@
// iterative radix-4 restoring divider, 20-bit dividend by 12-bit divisor
// depends on lcdnw_pkg; divisor must be nonzero
module lcdnw_div import lcdnw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [ADDR_W-1:0]  dividend,
  input  logic [PITCH_W-1:0] divisor,
  output logic               done,
  output div_res_t           res
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PITCH_W-1:0]   rem_r, rem_nxt;
  logic [ADDR_W-1:0]    quo_r, quo_nxt;
  logic [PITCH_W-1:0]   div_r, div_nxt;
  logic [PITCH_W-1:0]   rem_step;
  logic [ADDR_W-1:0]    quo_step;
  logic [PITCH_W:0]     trial;

  // two dependent restoring steps per cycle
  always_comb begin
    rem_step = rem_r;
    quo_step = quo_r;
    trial    = '0;
    for (int k = 0; k < 2; k++) begin
      trial    = {rem_step, quo_step[ADDR_W-1]};
      quo_step = {quo_step[ADDR_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        trial       = trial - {1'b0, div_r};
        quo_step[0] = 1'b1;
      end
      rem_step = trial[PITCH_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = rem_step;
      quo_nxt = quo_step;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done    = done_r;
  assign res.quo = quo_r;
  assign res.rem = rem_r;

endmodule

@@ design/lcd_nibble_write_mapper.sv @@
// lcd nibble write mapper: one write word in, zero or more changed-nibble words out.
// a write to a single place runs through the radix-4 divider and a shadow read-compare-write;
// a zero-pitch write skips the divider and reads, compares and writes the same column on each
// row below last_line; output stalls hold both. no new write is taken until the last one is done.
// after reset a clearing pass over all SHADOW_COLS*SCREEN_ROWS entries (2304 by default)
// marks every shadow entry unknown; no write is taken until it ends.
module lcd_nibble_write_mapper import lcdnw_pkg::*; #(
  parameter int ROW_NIBBLES = ROW_NIBBLES_DEF,
  parameter int SHADOW_COLS = SHADOW_COLS_DEF,
  parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
  parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  lcdnw_in_if.sink              in_bus,
  lcdnw_out_if.source           out_bus
);

  localparam int DEPTH = SHADOW_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(SHADOW_COLS);
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int RW1   = RW + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_DIV, S_RD, S_CMP, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  dstart_r, dstart_nxt;
  logic [PITCH_W-1:0] pitch_r, pitch_nxt;
  logic [LINE_W-1:0]  lline_r, lline_nxt;
  logic [ADDR_W-1:0]  mstart_r, mstart_nxt;

  logic [AW-1:0]      clr_r, clr_nxt;
  logic               cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]  off_r, off_nxt;
  logic [NIB_W-1:0]   nib_r, nib_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [RW1-1:0]     row_end_r, row_end_nxt;

  logic               pend_v_r, pend_v_nxt;
  logic [CW-1:0]      pend_col_r, pend_col_nxt;
  logic [RW-1:0]      pend_row_r, pend_row_nxt;
  logic [NIB_W-1:0]   pend_pat_r, pend_pat_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [COL_OUT_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_OUT_W-1:0] out_row_r, out_row_nxt;
  logic [NIB_W-1:0]     out_pat_r, out_pat_nxt;
  logic [NIB_W-1:0]     out_vis_r, out_vis_nxt;
  logic                 out_last_r, out_last_nxt;

  logic               in_fire;
  logic [ADDR_W:0]    diff;
  logic               slot_free;
  logic               push;
  logic               push_last;
  logic               changed;
  logic               row_done;
  logic [ADDR_W:0]    menu_row;

  logic               div_start;
  logic [PITCH_W-1:0] div_divisor;
  logic               div_done;
  div_res_t           div_res;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [SHADOW_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_addr;
  logic [SHADOW_W-1:0] ram_rdata;

  lcdnw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (off_r),
    .divisor  (div_divisor),
    .done     (div_done),
    .res      (div_res)
  );

  lcdnw_ram #(
    .WIDTH (SHADOW_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_shadow (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign diff         = in_bus.cmd ? ({1'b0, in_bus.address} - {1'b0, mstart_r})
                                   : ({1'b0, in_bus.address} - {1'b0, dstart_r});
  assign slot_free    = !out_valid_r || out_bus.ready;
  assign ram_addr     = AW'(row_r) * AW'(SHADOW_COLS) + AW'(col_r);
  assign changed      = (ram_rdata != {1'b0, nib_r});
  assign row_done     = (RW1'(row_r) + RW1'(1) == row_end_r);
  assign menu_row     = {1'b0, div_res.quo} + (ADDR_W + 1)'(lline_r) + (ADDR_W + 1)'(1);
  assign div_divisor  = cmd_r ? PITCH_W'(ROW_NIBBLES) : pitch_r;

  always_comb begin
    state_nxt     = state_r;
    dstart_nxt    = dstart_r;
    pitch_nxt     = pitch_r;
    lline_nxt     = lline_r;
    mstart_nxt    = mstart_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    off_nxt       = off_r;
    nib_nxt       = nib_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    row_end_nxt   = row_end_r;
    pend_v_nxt    = pend_v_r;
    pend_col_nxt  = pend_col_r;
    pend_row_nxt  = pend_row_r;
    pend_pat_nxt  = pend_pat_r;
    push          = 1'b0;
    push_last     = 1'b0;
    div_start     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = ram_addr;
    ram_wdata     = {1'b0, nib_r};
    ram_re        = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DISPLAY_START: dstart_nxt = cfg_wdata[ADDR_W-1:0];
        CFG_LINE_PITCH:    pitch_nxt  = cfg_wdata[PITCH_W-1:0];
        CFG_LAST_LINE:     lline_nxt  = cfg_wdata[LINE_W-1:0];
        CFG_MENU_START:    mstart_nxt = cfg_wdata[ADDR_W-1:0];
        default:           ;
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = SHADOW_UNKNOWN;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        // address below its area start is dropped
        if (in_fire && !diff[ADDR_W]) begin
          cmd_nxt   = in_bus.cmd;
          off_nxt   = diff[ADDR_W-1:0];
          nib_nxt   = in_bus.nibble;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (!cmd_r && pitch_r == '0) begin
          // zero pitch: same column on rows 0 .. last_line-1, capped at SCREEN_ROWS-1
          col_nxt = CW'(off_r);
          row_nxt = '0;
          if (int'(lline_r) < SCREEN_ROWS) row_end_nxt = RW1'(lline_r);
          else row_end_nxt = RW1'(SCREEN_ROWS);
          if (off_r >= ADDR_W'(SHADOW_COLS) || lline_r == '0) state_nxt = S_IDLE;
          else state_nxt = S_RD;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          col_nxt = CW'(div_res.rem);
          if (cmd_r) begin
            row_nxt     = RW'(menu_row);
            row_end_nxt = RW1'(menu_row) + RW1'(1);
            if (div_res.rem >= PITCH_W'(SHADOW_COLS) ||
                menu_row >= (ADDR_W + 1)'(SCREEN_ROWS)) state_nxt = S_IDLE;
            else state_nxt = S_RD;
          end else begin
            row_nxt     = RW'(div_res.quo);
            row_end_nxt = RW1'(div_res.quo) + RW1'(1);
            if (div_res.rem >= PITCH_W'(SHADOW_COLS) ||
                div_res.quo >= ADDR_W'(SCREEN_ROWS)) state_nxt = S_IDLE;
            else state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!changed || !pend_v_r || slot_free) begin
          if (changed) begin
            ram_we       = 1'b1;
            push         = pend_v_r;
            pend_v_nxt   = 1'b1;
            pend_col_nxt = col_r;
            pend_row_nxt = row_r;
            pend_pat_nxt = nib_r;
          end
          if (row_done) begin
            state_nxt = S_FIN;
          end else begin
            row_nxt   = row_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_FIN: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register fed from the pending word
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_pat_nxt   = out_pat_r;
    out_vis_nxt   = out_vis_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_col_nxt   = COL_OUT_W'(pend_col_r);
      out_row_nxt   = ROW_OUT_W'(pend_row_r);
      out_pat_nxt   = pend_pat_r;
      out_vis_nxt   = vis_mask(int'(pend_col_r), FRAME_WIDTH);
      out_last_nxt  = push_last;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    off_r      <= off_nxt;
    nib_r      <= nib_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    row_end_r  <= row_end_nxt;
    pend_col_r <= pend_col_nxt;
    pend_row_r <= pend_row_nxt;
    pend_pat_r <= pend_pat_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_pat_r  <= out_pat_nxt;
    out_vis_r  <= out_vis_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      dstart_r    <= DISPLAY_START_RST;
      pitch_r     <= LINE_PITCH_RST;
      lline_r     <= LAST_LINE_RST;
      mstart_r    <= MENU_START_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      dstart_r    <= dstart_nxt;
      pitch_r     <= pitch_nxt;
      lline_r     <= lline_nxt;
      mstart_r    <= mstart_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.column       = out_col_r;
  assign out_bus.row          = out_row_r;
  assign out_bus.pattern      = out_pat_r;
  assign out_bus.visible_mask = out_vis_r;
  assign out_bus.last         = out_last_r;

endmodule
